/* hdl/qspd_pkg.sv */
// Package for the query string percent decoder.
// Holds the channel item types, the result kind codes and the character constants.
// No dependencies.
package qspd_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_query;
  } query_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] decoded_byte;
    logic       run_last;
  } result_item_t;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_DROP   = 2'd3;

  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // One input byte causes at most this many results.
  localparam int unsigned MAX_RESULTS = 4;
  // Number of bundles the queue between front and back holds.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } entry_t;

  // All results caused by one input byte, oldest in entry 0.
  typedef struct packed {
    logic [2:0]         count;
    entry_t [MAX_RESULTS-1:0] ent;
  } bundle_t;

endpackage

/* hdl/qspd_front.sv */
// Front part of the query string percent decoder: parse state and classification.
// Turns each accepted byte into a bundle of results. Depends on qspd_pkg.
module qspd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 query_valid,
  output logic                 query_ready,
  input  qspd_pkg::query_item_t query,
  input  logic                 queue_full,
  output logic                 push,
  output qspd_pkg::bundle_t    bundle
);
  import qspd_pkg::*;

  logic       in_value;
  logic [1:0] pending_count;
  logic [3:0] pending_nibble;
  logic [7:0] pending_char;

  logic       in_value_next;
  logic [1:0] pending_count_next;
  logic [3:0] pending_nibble_next;
  logic [7:0] pending_char_next;

  logic       accept;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    // Bit 4 flags a valid hex digit; bits 3:0 hold its value.
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic bundle_t append(input bundle_t bd, input logic [1:0] k,
                                     input logic [7:0] d);
    bundle_t r;
    r = bd;
    if (bd.count < 3'(MAX_RESULTS)) begin
      r.ent[bd.count[1:0]].kind = k;
      r.ent[bd.count[1:0]].data = d;
      r.count = bd.count + 3'd1;
    end
    return r;
  endfunction

  assign query_ready = !queue_full;
  assign accept      = query_valid && query_ready;
  assign push        = accept && (bundle.count != 3'd0);

  always_comb begin
    logic [7:0] b;
    logic       eoq;
    logic [4:0] hv;
    logic       is_amp;
    logic       eq_key;
    logic       feed;
    logic       flush_old;
    logic       fresh;
    logic       decode;
    logic [1:0] npc;
    logic [1:0] dk;
    logic       accept_pair;
    bundle_t    bd;

    b   = query.byte_in;
    eoq = query.end_of_query;
    hv  = hex_value(b);
    is_amp = (b == CHAR_AMP);
    eq_key = (b == CHAR_EQ) && !in_value;
    feed   = !is_amp && !eq_key;
    flush_old = is_amp || eq_key || (feed && pending_count != 2'd0 && !hv[4]);
    fresh  = feed && (pending_count == 2'd0 || !hv[4]);
    decode = feed && pending_count == 2'd2 && hv[4];
    dk     = in_value ? KIND_VALUE : KIND_KEY;
    accept_pair = in_value || eq_key;

    npc = 2'd0;
    if (fresh && b == CHAR_PCT) begin
      npc = 2'd1;
    end else if (feed && pending_count == 2'd1 && hv[4]) begin
      npc = 2'd2;
    end

    bd = '0;
    // An escape broken by this byte, or cut short by the end of the part.
    if (flush_old && pending_count != 2'd0) begin
      bd = append(bd, dk, CHAR_PCT);
    end
    if (flush_old && pending_count == 2'd2) begin
      bd = append(bd, dk, pending_char);
    end
    if (fresh && b != CHAR_PCT) begin
      bd = append(bd, dk, (b == CHAR_PLUS) ? CHAR_SPACE : b);
    end
    if (decode) begin
      bd = append(bd, dk, {pending_nibble, hv[3:0]});
    end
    // The final byte leaves an escape that this byte itself opened or extended.
    if (feed && eoq && npc != 2'd0) begin
      bd = append(bd, dk, CHAR_PCT);
    end
    if (feed && eoq && npc == 2'd2) begin
      bd = append(bd, dk, b);
    end
    if (is_amp || eoq) begin
      bd = append(bd, accept_pair ? KIND_ACCEPT : KIND_DROP, 8'h00);
    end
    bundle = bd;

    in_value_next       = in_value;
    pending_count_next  = pending_count;
    pending_nibble_next = pending_nibble;
    pending_char_next   = pending_char;
    if (eoq || is_amp) begin
      in_value_next       = 1'b0;
      pending_count_next  = 2'd0;
      pending_nibble_next = 4'd0;
      pending_char_next   = 8'd0;
    end else if (eq_key) begin
      in_value_next       = 1'b1;
      pending_count_next  = 2'd0;
      pending_nibble_next = 4'd0;
      pending_char_next   = 8'd0;
    end else begin
      pending_count_next = npc;
      if (npc == 2'd2) begin
        pending_nibble_next = hv[3:0];
        pending_char_next   = b;
      end else if (npc == 2'd0) begin
        pending_nibble_next = 4'd0;
        pending_char_next   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value       <= 1'b0;
      pending_count  <= 2'd0;
      pending_nibble <= 4'd0;
      pending_char   <= 8'd0;
    end else if (accept) begin
      in_value       <= in_value_next;
      pending_count  <= pending_count_next;
      pending_nibble <= pending_nibble_next;
      pending_char   <= pending_char_next;
    end
  end

endmodule

/* hdl/qspd_queue.sv */
// Bundle queue between the front and back parts of the percent decoder.
// Small register FIFO of result bundles. Depends on qspd_pkg.
module qspd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qspd_pkg::bundle_t push_bundle,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output qspd_pkg::bundle_t head
);
  import qspd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  bundle_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     fill;

  assign full      = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* hdl/qspd_back.sv */
// Back part of the percent decoder: serialises the head bundle onto the result channel.
// Marks the last result of each bundle. Depends on qspd_pkg.
module qspd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  qspd_pkg::bundle_t     head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_ready,
  output qspd_pkg::result_item_t result
);
  import qspd_pkg::*;

  logic [1:0] idx;
  logic       last;

  assign last         = ({1'b0, idx} + 3'd1) == head.count;
  assign result_valid = not_empty;
  assign pop          = result_valid && result_ready && last;

  always_comb begin
    result.kind         = head.ent[idx].kind;
    result.decoded_byte = head.ent[idx].data;
    result.run_last     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (result_valid && result_ready) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

/* hdl/query_string_percent_decoder_core.sv */
// Top level of the query string percent decoder.
// Joins the front, the bundle queue and the back. Depends on qspd_pkg and the qspd modules.
//
// This block takes a form-encoded query string one byte per item and emits the decoded key
// and value bytes, each pair closed by a marker item that says whether the pair held an '='
// (accepted) or not (dropped). A '+' becomes a space, and '%' with two hex digits becomes one
// byte; a broken escape is passed on literally. A query byte is taken in the cycle it arrives
// whenever the bundle queue has room, and every byte is classified in that single cycle into
// a bundle of zero to four results. The queue holds four such bundles, so the input side
// keeps running while results wait to be taken. The result port delivers one item per cycle
// while result_ready is high, so a byte holds the output for as many items as it has results;
// with the usual one result per byte the sustained rate is one byte per cycle, and the output
// port sets the rate when bursts of separators and broken escapes arrive. Bytes that cause no
// result (a '%', a held hex digit, or a key-ending '=') leave nothing in the queue. The
// final-byte flag returns all parse state to its reset values. Each bundle is registered in
// the queue before its first result is offered on the result port.
module query_string_percent_decoder_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   query_valid,
  output logic                   query_ready,
  input  qspd_pkg::query_item_t  query,
  output logic                   result_valid,
  input  logic                   result_ready,
  output qspd_pkg::result_item_t result
);
  import qspd_pkg::*;

  // Front to queue.
  logic    push;
  bundle_t bundle;

  // Queue to back, and queue status back to the front.
  logic    queue_full;
  logic    not_empty;
  logic    pop;
  bundle_t head;

  // The front holds the parse state and turns each byte into a bundle combinationally.
  qspd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_ready (query_ready),
    .query       (query),
    .queue_full  (queue_full),
    .push        (push),
    .bundle      (bundle)
  );

  // The queue decouples the two sides so that each can stall on its own.
  qspd_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (bundle),
    .pop         (pop),
    .full        (queue_full),
    .not_empty   (not_empty),
    .head        (head)
  );

  // The back walks through the head bundle, one result per accepted output item.
  qspd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (not_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
